### hdl/derb_pkg.sv
// shared types, codes and widths of the double-ended ring buffer
`default_nettype none

package derb_pkg;

    // widths fixed by the item and result formats
    localparam int OP_W   = 3;
    localparam int OFFS_W = 4;
    localparam int ST_W   = 2;
    localparam int CNT_W  = 5;

    // parameter defaults
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // capacity after reset
    localparam int CAP_RESET = 16;

    // operation codes
    localparam logic [OP_W-1:0] OP_BACK_PUSH  = 3'd0;
    localparam logic [OP_W-1:0] OP_FRONT_PUSH = 3'd1;
    localparam logic [OP_W-1:0] OP_BACK_POP   = 3'd2;
    localparam logic [OP_W-1:0] OP_FRONT_POP  = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK       = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

    // status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_PEEK_OOR  = 2'd2;
    localparam logic [ST_W-1:0] ST_OVERWRITE = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic load_out;
    } derb_cmd_t;

endpackage

`default_nettype wire

### hdl/derb_req_if.sv
// request channel: operation, data word and peek offset
`default_nettype none

interface derb_req_if
    import derb_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();

    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       operation;
    logic [DATA_WIDTH-1:0] item;
    logic [OFFS_W-1:0]     offset;

    modport source (
        output valid,
        input  ready,
        output operation,
        output item,
        output offset
    );

    modport sink (
        input  valid,
        output ready,
        input  operation,
        input  item,
        input  offset
    );

endinterface

`default_nettype wire

### hdl/derb_rsp_if.sv
// result channel: read data, status and fill level
`default_nettype none

interface derb_rsp_if
    import derb_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();

    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] read_data;
    logic                  read_valid;
    logic [ST_W-1:0]       status;
    logic [CNT_W-1:0]      fill_count;
    logic                  is_empty;
    logic                  is_full;

    modport source (
        output valid,
        input  ready,
        output read_data,
        output read_valid,
        output status,
        output fill_count,
        output is_empty,
        output is_full
    );

    modport sink (
        input  valid,
        output ready,
        input  read_data,
        input  read_valid,
        input  status,
        input  fill_count,
        input  is_empty,
        input  is_full
    );

endinterface

`default_nettype wire

### hdl/derb_ctrl.sv
// controller state machine: capture, execute, deliver
`default_nettype none

module derb_ctrl
    import derb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    output derb_cmd_t       cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        // result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // output register free or emptying this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_EXEC))
        else $error("accepted transfer not executed next cycle");

    a_load_in_fin: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (state_reg == S_FIN))
        else $error("output loaded outside finish state");

    a_valid_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_FIN))
        else $error("result valid raised without a finished operation");

endmodule

`default_nettype wire

### hdl/derb_dp.sv
// datapath: entry memory, ring pointers, fill count and result registers
`default_nettype none

module derb_dp
    import derb_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire derb_cmd_t             cmd,
    input  wire logic                  cfg_we,
    input  wire logic [CNT_W-1:0]      cfg_wdata,
    input  wire logic [OP_W-1:0]       operation,
    input  wire logic [DATA_WIDTH-1:0] item,
    input  wire logic [OFFS_W-1:0]     offset,
    output logic [DATA_WIDTH-1:0]      read_data,
    output logic                       read_valid,
    output logic [ST_W-1:0]            status,
    output logic [CNT_W-1:0]           fill_count,
    output logic                       is_empty,
    output logic                       is_full
);

    localparam int IW = $clog2(DEPTH);
    // arithmetic width: holds DEPTH, capacity and head plus offset
    localparam int AW = ((IW > CNT_W) ? IW : CNT_W) + 1;

    function automatic logic [AW-1:0] cap_clamp(input logic [AW-1:0] w);
        logic [AW-1:0] c;
        c = w;
        if (w == '0)
        begin
            c = AW'(1);
        end
        else if (w > AW'(DEPTH))
        begin
            c = AW'(DEPTH);
        end
        return c;
    endfunction

    // entry memory
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] mem_q_reg;

    // captured request
    logic [OP_W-1:0]       op_reg;
    logic [DATA_WIDTH-1:0] item_reg;
    logic [OFFS_W-1:0]     offs_reg;

    // ring state
    logic [AW-1:0]    cap_reg;
    logic [IW-1:0]    head_reg, head_next;
    logic [IW-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // staged result of the executed operation
    logic             rvalid_reg, rvalid_next;
    logic [ST_W-1:0]  st_reg, st_next;

    // output registers
    logic [DATA_WIDTH-1:0] rdata_out_reg;
    logic                  rvalid_out_reg;
    logic [ST_W-1:0]       st_out_reg;
    logic [CNT_W-1:0]      fill_out_reg;
    logic                  empty_out_reg;
    logic                  full_out_reg;

    logic          mem_we, mem_re;
    logic [IW-1:0] waddr, raddr;

    logic [AW-1:0] head_ext, tail_ext, count_ext, pos_sum;
    logic [IW-1:0] head_inc, head_dec, tail_inc, tail_dec, peek_pos;
    logic          full_now, empty_now;

    always_comb
    begin
        head_ext  = AW'(head_reg);
        tail_ext  = AW'(tail_reg);
        count_ext = AW'(count_reg);
        head_inc  = ((head_ext + AW'(1)) >= cap_reg) ? '0 : (head_reg + IW'(1));
        tail_inc  = ((tail_ext + AW'(1)) >= cap_reg) ? '0 : (tail_reg + IW'(1));
        head_dec  = (head_reg == '0) ? IW'(cap_reg - AW'(1)) : (head_reg - IW'(1));
        tail_dec  = (tail_reg == '0) ? IW'(cap_reg - AW'(1)) : (tail_reg - IW'(1));
        pos_sum   = head_ext + AW'(offs_reg);
        if (pos_sum >= cap_reg)
        begin
            pos_sum = pos_sum - cap_reg;
        end
        peek_pos  = pos_sum[IW-1:0];
        full_now  = (count_ext >= cap_reg);
        empty_now = (count_reg == '0);
    end

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        rvalid_next = 1'b0;
        st_next     = ST_OK;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        waddr       = tail_reg;
        raddr       = head_reg;
        unique case (op_reg)
            OP_BACK_PUSH:
            begin
                mem_we    = 1'b1;
                waddr     = tail_reg;
                tail_next = tail_inc;
                if (full_now)
                begin
                    head_next = tail_inc;
                    st_next   = ST_OVERWRITE;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_FRONT_PUSH:
            begin
                mem_we    = 1'b1;
                waddr     = head_dec;
                head_next = head_dec;
                if (full_now)
                begin
                    tail_next = head_dec;
                    st_next   = ST_OVERWRITE;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_BACK_POP:
            begin
                if (empty_now)
                begin
                    st_next = ST_POP_EMPTY;
                end
                else
                begin
                    mem_re      = 1'b1;
                    raddr       = tail_dec;
                    tail_next   = tail_dec;
                    rvalid_next = 1'b1;
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            OP_FRONT_POP:
            begin
                if (empty_now)
                begin
                    st_next = ST_POP_EMPTY;
                end
                else
                begin
                    mem_re      = 1'b1;
                    raddr       = head_reg;
                    head_next   = head_inc;
                    rvalid_next = 1'b1;
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            OP_PEEK:
            begin
                if (CNT_W'(offs_reg) >= count_reg)
                begin
                    st_next = ST_PEEK_OOR;
                end
                else
                begin
                    mem_re      = 1'b1;
                    raddr       = peek_pos;
                    rvalid_next = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    // memory: at most one write or one registered read per operation, never both
    always_ff @(posedge clk)
    begin
        if (cmd.exec && mem_we)
        begin
            mem[waddr] <= item_reg;
        end
        if (cmd.exec && mem_re)
        begin
            mem_q_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= operation;
            item_reg <= item;
            offs_reg <= offset;
        end
        if (cmd.exec)
        begin
            st_reg <= st_next;
        end
        if (cmd.load_out)
        begin
            rdata_out_reg  <= rvalid_reg ? mem_q_reg : '0;
            rvalid_out_reg <= rvalid_reg;
            st_out_reg     <= st_reg;
            fill_out_reg   <= count_reg;
            empty_out_reg  <= (count_reg == '0);
            full_out_reg   <= (AW'(count_reg) == cap_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= cap_clamp(AW'(CAP_RESET));
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            cap_reg   <= cap_clamp(AW'(cfg_wdata));
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            rvalid_reg <= rvalid_next;
        end
    end

    assign read_data  = rdata_out_reg;
    assign read_valid = rvalid_out_reg;
    assign status     = st_out_reg;
    assign fill_count = fill_out_reg;
    assign is_empty   = empty_out_reg;
    assign is_full    = full_out_reg;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        AW'(count_reg) <= cap_reg)
        else $error("fill count above capacity");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (AW'(head_reg) < cap_reg) && (AW'(tail_reg) < cap_reg))
        else $error("ring pointer outside capacity");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty ring with head and tail apart");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> !(mem_we && mem_re))
        else $error("memory written and read by one operation");

endmodule

`default_nettype wire

### hdl/double_ended_ring_buffer.sv
// top level of the double-ended ring buffer
//
//  channel   dir  handshake        payload
//  request   in   valid / ready    operation, item, offset
//  result    out  valid / ready    read_data, read_valid, status, fill_count,
//                                  is_empty, is_full
//  cfg       in   cfg_we           cfg_wdata = capacity in use
//
//  one operation runs from transfer to result as capture, then execute
//  (pointer update, memory write or read issue), then load of the output register
//  once the registered memory read data is back
//  the next request transfer is taken while the previous result still waits
//  async active-low reset: empty ring, capacity 16 (clamped to DEPTH); no
//  clearing pass, memory content is only read after being written
//  a stalled result holds its registers; the controller then waits in the
//  finish state and takes no new request
`default_nettype none

module double_ended_ring_buffer
    import derb_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CNT_W-1:0] cfg_wdata,
    derb_req_if.sink              request,
    derb_rsp_if.source            result
);

    // command bundle from controller to datapath
    derb_cmd_t cmd;

    // controller owns the handshakes on both channels
    derb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    // datapath holds the memory, ring pointers and result registers
    derb_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .operation  (request.operation),
        .item       (request.item),
        .offset     (request.offset),
        .read_data  (result.read_data),
        .read_valid (result.read_valid),
        .status     (result.status),
        .fill_count (result.fill_count),
        .is_empty   (result.is_empty),
        .is_full    (result.is_full)
    );

endmodule

`default_nettype wire
